// ===== design/rrts_pkg.sv =====
// Shared types and constants of the round-robin tick scheduler.
package rrts_pkg;

  // Default depth of the task table.
  localparam int unsigned RRTS_MAX_TASKS = 16;

  // Field widths of the input and result transactions.
  localparam int unsigned SLICE_W  = 8;
  localparam int unsigned IRQ_W    = 8;
  localparam int unsigned TASK_W   = 4;
  localparam int unsigned TOTAL_W  = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned TICKS_W  = 64;

  // Interrupt numbers from this one upward also belong to the slave controller.
  localparam logic [IRQ_W-1:0] SLAVE_IRQ_FIRST = IRQ_W'(40);

  // Action codes of an input transaction.
  typedef enum logic {
    ACT_ADD  = 1'b0,
    ACT_TICK = 1'b1
  } action_e;

  // Status codes of a result transaction.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // One entry of the task table: slice length and remaining ticks.
  typedef struct packed {
    logic [SLICE_W-1:0] slice;
    logic [SLICE_W-1:0] ticks;
  } entry_t;

endpackage

// ===== design/rrts_in_if.sv =====
// Input channel of the round-robin tick scheduler.
interface rrts_in_if
  import rrts_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               action;
  logic [SLICE_W-1:0] slice_ticks;
  logic [IRQ_W-1:0]   irq_vector;

  modport source (output valid, output action, output slice_ticks, output irq_vector,
                  input ready);
  modport sink   (input valid, input action, input slice_ticks, input irq_vector,
                  output ready);
endinterface

// ===== design/rrts_out_if.sv =====
// Result channel of the round-robin tick scheduler.
interface rrts_out_if
  import rrts_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [TASK_W-1:0]   current_task;
  logic                switched;
  logic                ack_master;
  logic                ack_slave;
  logic [STATUS_W-1:0] status;
  logic [TOTAL_W-1:0]  task_total;
  logic [TICKS_W-1:0]  idle_count;
  logic [TICKS_W-1:0]  busy_count;

  modport source (output valid, output current_task, output switched, output ack_master,
                  output ack_slave, output status, output task_total, output idle_count,
                  output busy_count, input ready);
  modport sink   (input valid, input current_task, input switched, input ack_master,
                  input ack_slave, input status, input task_total, input idle_count,
                  input busy_count, output ready);
endinterface

// ===== design/round_robin_tick_scheduler.sv =====
// Round-robin tick scheduler: task table in a synchronous memory, one result per transaction.
//
// Each input transaction either appends a task with its slice length or delivers a timer
// tick; every transaction gives exactly one result. For a tick, the running task's table
// entry is read at the accepting edge from a single-port synchronous memory, and in the
// execute step the entry is updated and written back (an add writes its new entry there)
// while the result is loaded into the output register. The input is ready again right
// after that, so a new item can follow as soon as a result is loaded; the block
// accepts the next item while a result still waits, and holds that item in its execute step
// until the output register frees up. There is no clearing pass after reset: table entries
// are only used after an add has written them.
module round_robin_tick_scheduler
  import rrts_pkg::*;
#(
  parameter int unsigned MAX_TASKS = RRTS_MAX_TASKS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rrts_in_if.sink    in_i,
  rrts_out_if.source out_o
);

  localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e st_q, st_d;

  // Scheduler state.
  logic [IDX_W-1:0]   run_q, run_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [TICKS_W-1:0] idle_q, idle_d;
  logic [TICKS_W-1:0] busy_q, busy_d;

  // Latched input transaction.
  logic               act_q;
  logic [SLICE_W-1:0] slice_q;
  logic [IRQ_W-1:0]   irq_q;

  // Result flags held in the output register.
  logic                out_valid_q, out_valid_d;
  logic                sw_q, sw_d;
  logic                ackm_q, ackm_d;
  logic                acks_q, acks_d;
  logic [STATUS_W-1:0] stat_q, stat_d;

  // Task table memory and its port signals.
  entry_t             mem [MAX_TASKS];
  entry_t             rd_q;
  logic               rd_en;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;

  logic               in_fire;
  logic               done;
  logic [SLICE_W-1:0] ticks_dec;
  logic [CNT_W-1:0]   next_run;
  logic [IDX_W+3:0]   run_ext;
  logic [CNT_W+4:0]   cnt_ext;

  assign in_i.ready = (st_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign done       = (st_q == ST_EXEC) && (!out_valid_q || out_o.ready);

  // Read the running task's entry as a tick transaction is accepted.
  assign rd_en = in_fire && (action_e'(in_i.action) == ACT_TICK);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[run_q];
    end
  end

  // Latch the accepted transaction.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q   <= in_i.action;
      slice_q <= in_i.slice_ticks;
      irq_q   <= in_i.irq_vector;
    end
  end

  assign ticks_dec = (rd_q.ticks != '0) ? rd_q.ticks - SLICE_W'(1) : '0;
  assign next_run  = CNT_W'(run_q) + CNT_W'(1);

  // Execute step: update the table entry and scheduler state, build the result.
  always_comb begin
    st_d        = st_q;
    run_d       = run_q;
    cnt_d       = cnt_q;
    idle_d      = idle_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    sw_d        = sw_q;
    ackm_d      = ackm_q;
    acks_d      = acks_q;
    stat_d      = stat_q;
    wr_en       = 1'b0;
    wr_addr     = run_q;
    wr_data     = rd_q;

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (st_q)
      ST_IDLE: begin
        if (in_fire) begin
          st_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (done) begin
          st_d        = ST_IDLE;
          out_valid_d = 1'b1;
          sw_d        = 1'b0;
          ackm_d      = 1'b0;
          acks_d      = 1'b0;
          stat_d      = STATUS_OK;
          if (action_e'(act_q) == ACT_ADD) begin
            if (cnt_q == CNT_W'(MAX_TASKS)) begin
              stat_d = STATUS_FULL;
            end else begin
              wr_en         = 1'b1;
              wr_addr       = cnt_q[IDX_W-1:0];
              wr_data.slice = slice_q;
              wr_data.ticks = slice_q;
              cnt_d         = cnt_q + CNT_W'(1);
            end
          end else if (cnt_q == '0) begin
            stat_d = STATUS_EMPTY;
          end else begin
            if (run_q == '0) begin
              idle_d = idle_q + TICKS_W'(1);
            end else begin
              busy_d = busy_q + TICKS_W'(1);
            end
            wr_en = 1'b1;
            if (ticks_dec == '0) begin
              // Slice ended: reload and advance to the next task.
              wr_data.ticks = rd_q.slice;
              sw_d          = 1'b1;
              ackm_d        = 1'b1;
              acks_d        = (irq_q >= SLAVE_IRQ_FIRST);
              run_d         = (next_run >= cnt_q) ? '0 : next_run[IDX_W-1:0];
            end else begin
              wr_data.ticks = ticks_dec;
            end
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      run_q       <= '0;
      cnt_q       <= '0;
      idle_q      <= '0;
      busy_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      run_q       <= run_d;
      cnt_q       <= cnt_d;
      idle_q      <= idle_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result flags.
  always_ff @(posedge clk_i) begin
    sw_q   <= sw_d;
    ackm_q <= ackm_d;
    acks_q <= acks_d;
    stat_q <= stat_d;
  end

  // State changes only when a result is loaded, so the state registers serve as its payload.
  assign run_ext = {4'b0, run_q};
  assign cnt_ext = {5'b0, cnt_q};

  assign out_o.valid        = out_valid_q;
  assign out_o.current_task = run_ext[TASK_W-1:0];
  assign out_o.switched     = sw_q;
  assign out_o.ack_master   = ackm_q;
  assign out_o.ack_slave    = acks_q;
  assign out_o.status       = stat_q;
  assign out_o.task_total   = cnt_ext[TOTAL_W-1:0];
  assign out_o.idle_count   = idle_q;
  assign out_o.busy_count   = busy_q;

  // The task count never exceeds the table depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_TASKS))
    else $error("task count exceeds table depth");

  // The running index always points at a populated entry, or at zero when empty.
  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 && run_q == '0) || (CNT_W'(run_q) < cnt_q))
    else $error("running index outside the populated table");

  // A slave acknowledge comes only with a master acknowledge on a task switch.
  a_ack_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && acks_q) |-> (ackm_q && sw_q))
    else $error("slave acknowledge without master acknowledge");

  // An execute step with a free output register produces a result on the next edge.
  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_EXEC && !out_valid_q) |=> (out_valid_q && st_q == ST_IDLE))
    else $error("execute step did not produce a result");

endmodule
